// ----- hdl/i2cm_pkg.sv -----
package i2cm_pkg;

  // command codes on the input channel
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // bit-period indexes that mark the steps of each sequence
  localparam logic [5:0] PH_START_LAST = 6'd3;
  localparam logic [5:0] PH_STOP_LAST  = 6'd2;
  localparam logic [5:0] PH_WR_BITS    = 6'd16;
  localparam logic [5:0] PH_WR_SDA_REL = 6'd17;
  localparam logic [5:0] PH_WR_ACK     = 6'd18;
  localparam logic [5:0] PH_RD_BITS    = 6'd32;
  localparam logic [5:0] PH_RD_ACK_SDA = 6'd33;
  localparam logic [5:0] PH_RD_ACK_SCL = 6'd34;

  typedef enum logic [5:0] {
    OP_IDLE  = 6'b000001,
    OP_START = 6'b000010,
    OP_STOP  = 6'b000100,
    OP_WRITE = 6'b001000,
    OP_READ  = 6'b010000,
    OP_NSTOP = 6'b100000
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] phase;
    logic [7:0] shift;
    logic       nack;
    logic       scl;
    logic       sda;
  } seq_state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       auto_stopped;
    logic       cmd_rejected;
  } seq_res_t;

  localparam seq_state_t SEQ_STATE_RESET = '{
    op:    OP_IDLE,
    phase: 6'd0,
    shift: 8'd0,
    nack:  1'b0,
    scl:   1'b1,
    sda:   1'b1
  };

endpackage

// ----- hdl/i2cm_if.sv -----
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       send_nack;
  logic       sda_in;

  modport source (output valid, cmd, tx_byte, send_nack, sda_in, input ready);
  modport sink   (input valid, cmd, tx_byte, send_nack, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;
  logic       auto_stopped;
  logic       cmd_rejected;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  ack_received, auto_stopped, cmd_rejected, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  ack_received, auto_stopped, cmd_rejected, output ready);
endinterface

// ----- hdl/i2c_master_bit_sequencer_core.sv -----
// channel | dir | handshake     | payload
// in_ch   | in  | valid / ready | cmd, tx_byte, send_nack, sda_in
// out_ch  | out | valid / ready | scl_out, sda_out, busy_res, done_res, rx_byte,
//         |     |               | ack_received, auto_stopped, cmd_rejected
//
// one beat in gives exactly one beat out, in the cycle after acceptance
// one beat per cycle sustained while out_ch.ready stays high: the step logic sits
// between the sequence state and the result register, so throughput is set by that single register stage
// rst_n (synchronous) returns to idle with scl and sda released
// in_ch.ready drops only while a result is held and out_ch.ready is low
module i2c_master_bit_sequencer_core
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch
);

  seq_state_t state_r;
  seq_state_t state_nxt;
  seq_res_t   res_r;
  seq_res_t   res_nxt;
  logic       out_valid_r;
  logic       in_fire;

  // take a new beat whenever the result slot is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // one bit-period of the pin sequence
  i2cm_step u_step (
    .st        (state_r),
    .cmd       (in_ch.cmd),
    .tx_byte   (in_ch.tx_byte),
    .send_nack (in_ch.send_nack),
    .sda_in    (in_ch.sda_in),
    .st_nxt    (state_nxt),
    .res       (res_nxt)
  );

  // sequence state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scl_out      = res_r.scl_out;
  assign out_ch.sda_out      = res_r.sda_out;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.done_res     = res_r.done_res;
  assign out_ch.rx_byte      = res_r.rx_byte;
  assign out_ch.ack_received = res_r.ack_received;
  assign out_ch.auto_stopped = res_r.auto_stopped;
  assign out_ch.cmd_rejected = res_r.cmd_rejected;

  // a finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> (state_r.op == OP_IDLE))
    else $error("done reported but sequencer not idle");

  // busy flag agrees with the held sequence state
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.busy_res == (state_r.op != OP_IDLE)))
    else $error("busy flag disagrees with sequence state");

  // an idle sequencer never rejects a command
  a_no_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (state_r.op == OP_IDLE) |=> !res_r.cmd_rejected)
    else $error("command rejected while idle");

  // automatic stop only closes a write, never alongside an ack
  a_autostop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.auto_stopped |-> res_r.done_res && !res_r.ack_received)
    else $error("auto stop flagged without a nack completion");

endmodule

// ----- hdl/i2cm_step.sv -----
module i2cm_step
  import i2cm_pkg::*;
(
  input  seq_state_t st,
  input  logic [2:0] cmd,
  input  logic [7:0] tx_byte,
  input  logic       send_nack,
  input  logic       sda_in,
  output seq_state_t st_nxt,
  output seq_res_t   res
);

  logic       is_cmd;
  logic       last;
  logic       hold_phase;
  logic       rejected;
  logic       ack;
  logic       autos;
  logic [7:0] rx;
  op_t        op;
  logic [5:0] ph;
  logic [7:0] sh;
  logic       nk;
  logic       scl;
  logic       sda;

  assign is_cmd = (cmd == CMD_START) || (cmd == CMD_STOP) ||
                  (cmd == CMD_WRITE) || (cmd == CMD_READ);

  always_comb begin
    op         = st.op;
    ph         = st.phase;
    sh         = st.shift;
    nk         = st.nack;
    scl        = st.scl;
    sda        = st.sda;
    last       = 1'b0;
    hold_phase = 1'b0;
    rejected   = 1'b0;
    ack        = 1'b0;
    autos      = 1'b0;
    rx         = 8'd0;

    // command intake, only from idle
    if (is_cmd) begin
      if (op == OP_IDLE) begin
        priority if (cmd == CMD_START) begin
          op = OP_START;
        end else if (cmd == CMD_STOP) begin
          op = OP_STOP;
        end else if (cmd == CMD_WRITE) begin
          op = OP_WRITE;
        end else begin
          op = OP_READ;
        end
        ph = 6'd0;
        sh = (cmd == CMD_WRITE) ? tx_byte : 8'd0;
        nk = send_nack;
      end else begin
        rejected = 1'b1;
      end
    end

    unique case (op)
      OP_START: begin
        priority if (ph == 6'd0) begin
          sda = 1'b1;
        end else if (ph == 6'd1) begin
          scl = 1'b1;
        end else if (ph == 6'd2) begin
          sda = 1'b0;
        end else begin
          scl  = 1'b0;
          last = 1'b1;
        end
      end
      OP_STOP, OP_NSTOP: begin
        priority if (ph == 6'd0) begin
          sda = 1'b0;
        end else if (ph == 6'd1) begin
          scl = 1'b1;
        end else begin
          sda   = 1'b1;
          last  = 1'b1;
          autos = (op == OP_NSTOP);
        end
      end
      OP_WRITE: begin
        priority if (ph < PH_WR_BITS) begin
          if (!ph[0]) begin
            if (ph != 6'd0) begin
              scl = 1'b0;
            end
            sda = sh[7];
          end else begin
            scl = 1'b1;
            sh  = {sh[6:0], 1'b0};
          end
        end else if (ph == PH_WR_BITS) begin
          scl = 1'b0;
        end else if (ph == PH_WR_SDA_REL) begin
          sda = 1'b1;
        end else if (ph == PH_WR_ACK) begin
          scl = 1'b1;
          // nack from the slave: fall straight into a stop sequence
          if (sda_in) begin
            op         = OP_NSTOP;
            ph         = 6'd0;
            hold_phase = 1'b1;
          end
        end else begin
          scl  = 1'b0;
          ack  = 1'b1;
          last = 1'b1;
        end
      end
      OP_READ: begin
        priority if (ph < PH_RD_BITS) begin
          if (ph == 6'd0) begin
            sda = 1'b1;
          end
          if (ph[1:0] == 2'd1) begin
            scl = 1'b0;
          end else if (ph[1:0] == 2'd2) begin
            scl = 1'b1;
            sh  = {sh[6:0], sda_in};
          end
        end else if (ph == PH_RD_BITS) begin
          scl = 1'b0;
        end else if (ph == PH_RD_ACK_SDA) begin
          sda = nk;
        end else if (ph == PH_RD_ACK_SCL) begin
          scl = 1'b1;
        end else begin
          scl  = 1'b0;
          rx   = sh;
          last = 1'b1;
        end
      end
      default: begin
        op         = OP_IDLE;
        ph         = 6'd0;
        hold_phase = 1'b1;
      end
    endcase

    if (last) begin
      op = OP_IDLE;
      ph = 6'd0;
    end else if (!hold_phase) begin
      ph = ph + 6'd1;
    end
  end

  assign st_nxt = '{op: op, phase: ph, shift: sh, nack: nk, scl: scl, sda: sda};

  assign res = '{
    scl_out:      scl,
    sda_out:      sda,
    busy_res:     (op != OP_IDLE),
    done_res:     last,
    rx_byte:      rx,
    ack_received: ack,
    auto_stopped: autos,
    cmd_rejected: rejected
  };

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import i2cm_pkg::*;

  // codes the package leaves unnamed: the plain period and the spare codes
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_BEATS = 1680;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  tx_byte;
    logic        send_nack;
    logic        sda_in;
    int unsigned reps;
    bit          typed;
    seq_res_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_bit_sequencer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // own copy of the sequencer state, advanced once per accepted input beat
  op_t        bus_op;
  logic [5:0] bus_phase;
  logic [7:0] bus_shift;
  logic       bus_nack;
  logic       bus_scl;
  logic       bus_sda;

  seq_res_t    pending_periods[$];
  stim_row_t   script[$];
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned beats_sent;
  int unsigned directed_beats;
  int unsigned mismatches;
  int unsigned n_checked, n_done, n_acked, n_auto_stops, n_rejects;
  seq_res_t    seen;
  seq_res_t    want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bus levels and flags of one bit-delay period, walking the command's phase list
  function automatic seq_res_t next_bus_period(logic [2:0] cmd, logic [7:0] txb,
                                               logic nk, logic sdi);
    seq_res_t r;
    logic     last;
    logic     hold;
    r    = '0;
    last = 1'b0;
    hold = 1'b0;
    if (cmd >= CMD_START && cmd <= CMD_READ) begin
      if (bus_op == OP_IDLE) begin
        case (cmd)
          CMD_START: bus_op = OP_START;
          CMD_STOP:  bus_op = OP_STOP;
          CMD_WRITE: bus_op = OP_WRITE;
          default:   bus_op = OP_READ;
        endcase
        bus_phase = '0;
        bus_shift = (cmd == CMD_WRITE) ? txb : 8'd0;
        bus_nack  = nk;
      end else begin
        r.cmd_rejected = 1'b1;
      end
    end
    case (bus_op)
      OP_START: begin
        if (bus_phase == 6'd0) bus_sda = 1'b1;
        else if (bus_phase == 6'd1) bus_scl = 1'b1;
        else if (bus_phase == 6'd2) bus_sda = 1'b0;
        else begin
          bus_scl = 1'b0;
          last    = 1'b1;
        end
      end
      OP_STOP, OP_NSTOP: begin
        if (bus_phase == 6'd0) bus_sda = 1'b0;
        else if (bus_phase == 6'd1) bus_scl = 1'b1;
        else begin
          bus_sda        = 1'b1;
          last           = 1'b1;
          r.auto_stopped = (bus_op == OP_NSTOP);
        end
      end
      OP_WRITE: begin
        if (bus_phase < PH_WR_BITS) begin
          if (!bus_phase[0]) begin
            if (bus_phase != 6'd0) bus_scl = 1'b0;
            bus_sda = bus_shift[7];
          end else begin
            bus_scl   = 1'b1;
            bus_shift = {bus_shift[6:0], 1'b0};
          end
        end else if (bus_phase == PH_WR_BITS) begin
          bus_scl = 1'b0;
        end else if (bus_phase == PH_WR_SDA_REL) begin
          bus_sda = 1'b1;
        end else if (bus_phase == PH_WR_ACK) begin
          bus_scl = 1'b1;
          // slave left sda high: the stop goes out without being asked for
          if (sdi) begin
            bus_op    = OP_NSTOP;
            bus_phase = '0;
            hold      = 1'b1;
          end
        end else begin
          bus_scl        = 1'b0;
          r.ack_received = 1'b1;
          last           = 1'b1;
        end
      end
      OP_READ: begin
        if (bus_phase < PH_RD_BITS) begin
          if (bus_phase == 6'd0) bus_sda = 1'b1;
          if (bus_phase[1:0] == 2'd1) bus_scl = 1'b0;
          else if (bus_phase[1:0] == 2'd2) begin
            bus_scl   = 1'b1;
            bus_shift = {bus_shift[6:0], sdi};
          end
        end else if (bus_phase == PH_RD_BITS) begin
          bus_scl = 1'b0;
        end else if (bus_phase == PH_RD_ACK_SDA) begin
          bus_sda = bus_nack;
        end else if (bus_phase == PH_RD_ACK_SCL) begin
          bus_scl = 1'b1;
        end else begin
          bus_scl   = 1'b0;
          r.rx_byte = bus_shift;
          last      = 1'b1;
        end
      end
      default: begin
        // idle, or a spare code: levels held, nothing reported
        bus_op    = OP_IDLE;
        bus_phase = '0;
        hold      = 1'b1;
      end
    endcase
    if (last) begin
      r.done_res = 1'b1;
      bus_op     = OP_IDLE;
      bus_phase  = '0;
    end else if (!hold) begin
      bus_phase = bus_phase + 6'd1;
    end
    r.scl_out  = bus_scl;
    r.sda_out  = bus_sda;
    r.busy_res = (bus_op != OP_IDLE);
    return r;
  endfunction

  function automatic seq_res_t pins(logic scl, logic sda, logic busy, logic done,
                                    logic rej);
    seq_res_t r;
    r              = '0;
    r.scl_out      = scl;
    r.sda_out      = sda;
    r.busy_res     = busy;
    r.done_res     = done;
    r.cmd_rejected = rej;
    return r;
  endfunction

  task automatic add_row(logic [2:0] cmd, logic [7:0] txb, logic nk, logic sdi,
                         int unsigned reps, bit typed, seq_res_t w);
    stim_row_t row;
    row.cmd       = cmd;
    row.tx_byte   = txb;
    row.send_nack = nk;
    row.sda_in    = sdi;
    row.reps      = reps;
    row.typed     = typed;
    row.want      = w;
    script.push_back(row);
  endtask

  // entered at a falling edge, returns at the falling edge after acceptance;
  // typed rows stand in for the predicted period but the predictor still steps
  task automatic send_beat(logic [2:0] cmd, logic [7:0] txb, logic nk, logic sdi,
                           bit typed, seq_res_t w);
    seq_res_t got;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.tx_byte   <= txb;
    in_ch.send_nack <= nk;
    in_ch.sda_in    <= sdi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = next_bus_period(cmd, txb, nk, sdi);
    pending_periods.push_back(typed ? w : got);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(logic [2:0] cmd);
    send_beat(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'b0, '0);
  endtask

  // mostly complete commands with random content, some stray and spare codes
  task automatic random_transfer();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_random(3'($urandom_range(7)));
      return;
    end
    if (pick < 40) send_random(CMD_WRITE);
    else if (pick < 70) send_random(CMD_READ);
    else if (pick < 85) send_random(CMD_START);
    else send_random(CMD_STOP);
    while (bus_op != OP_IDLE) begin
      if ($urandom_range(99) < 4) send_random(3'($urandom_range(1, 7)));
      else send_random(CMD_TICK);
    end
    repeat ($urandom_range(2)) send_random(CMD_TICK);
  endtask

  // receiver side: stall at the rate of the current phase
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // every result beat is held against the oldest expected period
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.scl_out      = out_ch.scl_out;
      seen.sda_out      = out_ch.sda_out;
      seen.busy_res     = out_ch.busy_res;
      seen.done_res     = out_ch.done_res;
      seen.rx_byte      = out_ch.rx_byte;
      seen.ack_received = out_ch.ack_received;
      seen.auto_stopped = out_ch.auto_stopped;
      seen.cmd_rejected = out_ch.cmd_rejected;
      if (pending_periods.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected: %p", $realtime, seen);
      end else begin
        want = pending_periods.pop_front();
        n_checked++;
        n_done       += want.done_res;
        n_acked      += want.ack_received;
        n_auto_stops += want.auto_stopped;
        n_rejects    += want.cmd_rejected;
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: period %0d differs\n  expected %p\n  actual   %p",
                     $realtime, n_checked, want, seen);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_TICK;
    in_ch.tx_byte   = 8'd0;
    in_ch.send_nack = 1'b0;
    in_ch.sda_in    = 1'b0;
    out_ch.ready    = 1'b1;
    rst_n           = 1'b0;
    gap_pct         = 0;
    stall_pct       = 0;
    beats_sent      = 0;
    directed_beats  = 0;
    mismatches      = 0;
    n_checked       = 0;
    n_done          = 0;
    n_acked         = 0;
    n_auto_stops    = 0;
    n_rejects       = 0;
    bus_op          = OP_IDLE;
    bus_phase       = '0;
    bus_shift       = '0;
    bus_nack        = 1'b0;
    bus_scl         = 1'b1;
    bus_sda         = 1'b1;

    // idle after reset, spare codes behave as plain periods
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 1, 1'b1, pins(1, 1, 0, 0, 0));
    add_row(CMD_SPARE_HI, 8'hFF, 1'b1, 1'b1, 1, 1'b1, pins(1, 1, 0, 0, 0));
    add_row(CMD_SPARE_LO, 8'h00, 1'b0, 1'b1, 1, 1'b1, pins(1, 1, 0, 0, 0));
    // start condition with a write refused half-way
    add_row(CMD_START,    8'hFF, 1'b1, 1'b0, 1, 1'b1, pins(1, 1, 1, 0, 0));
    add_row(CMD_WRITE,    8'h00, 1'b0, 1'b0, 1, 1'b1, pins(1, 1, 1, 0, 1));
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 1, 1'b1, pins(1, 0, 1, 0, 0));
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 1, 1'b1, pins(0, 0, 0, 1, 0));
    // all-ones byte, slave answers NACK, stop issued on its own
    add_row(CMD_WRITE,    8'hFF, 1'b0, 1'b0, 1, 1'b0, '0);
    add_row(CMD_READ,     8'h00, 1'b1, 1'b0, 1, 1'b1, pins(1, 1, 1, 0, 1));
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 16, 1'b0, '0);
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b1, 1, 1'b0, '0);
    add_row(CMD_STOP,     8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 2, 1'b0, '0);
    // all-zeros byte acknowledged
    add_row(CMD_WRITE,    8'h00, 1'b1, 1'b1, 1, 1'b0, '0);
    add_row(CMD_TICK,     8'hFF, 1'b1, 1'b0, 18, 1'b0, '0);
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
    // reads of all ones answered NACK and all zeros answered ACK
    add_row(CMD_READ,     8'hFF, 1'b1, 1'b1, 1, 1'b0, '0);
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b1, 35, 1'b0, '0);
    add_row(CMD_READ,     8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 35, 1'b0, '0);
    // plain stop
    add_row(CMD_STOP,     8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 2, 1'b0, '0);
    add_row(CMD_TICK,     8'h00, 1'b0, 1'b0, 1, 1'b1, pins(1, 1, 0, 0, 0));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      repeat (script[i].reps)
        send_beat(script[i].cmd, script[i].tx_byte, script[i].send_nack,
                  script[i].sda_in, script[i].typed, script[i].want);
    directed_beats = beats_sent;

    // four idling phases, a quarter of the random beats each
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 56; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 56; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      while (beats_sent < directed_beats + (ph + 1) * RANDOM_BEATS / 4)
        random_transfer();
    end
    in_ch.valid <= 1'b0;

    while (pending_periods.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("bus periods checked: %0d, commands completed: %0d", n_checked, n_done);
    $display("writes acknowledged: %0d, automatic stops: %0d, busy refusals: %0d",
             n_acked, n_auto_stops, n_rejects);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
